// File: hdl/npcs_pkg.sv
// Shared types and constants for the nearest palette color search.
package npcs_pkg;

    localparam int PALETTE_COUNT       = 8;
    localparam int ENTRIES_PER_PALETTE = 16;
    localparam int TOTAL_ENTRIES       = PALETTE_COUNT * ENTRIES_PER_PALETTE;

    localparam int ADDR_W = (TOTAL_ENTRIES > 1) ? $clog2(TOTAL_ENTRIES) : 1;
    localparam int PAL_W  = (PALETTE_COUNT > 1) ? $clog2(PALETTE_COUNT) : 1;
    localparam int IDX_W  = $clog2(ENTRIES_PER_PALETTE);

    localparam int DIST_W   = 18;
    localparam int MAX_DIST = 4 * 255 * 255;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [6:0] entry_number;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } item_t;

    typedef struct packed {
        logic [2:0]        palette_number;
        logic [3:0]        entry_in_palette;
        logic [DIST_W-1:0] best_distance;
    } result_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } rgba_t;

    // Travels alongside each entry read through the distance pipeline.
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [PAL_W-1:0] pal;
        logic [IDX_W-1:0] idx;
    } tag_t;

endpackage

// File: hdl/nearest_palette_color_search.sv
// Top level: palette store, entry scan and running minimum.
// A load beat writes the store directly when it is taken.
// A query reads the store one entry per cycle; its result is registered from the hold state
// once the output is free, and no new beat is taken until the scan has drained and reached that state.
// A result left waiting at the output holds the next result, and with it the input.
// Reset clears control state only; store contents are undefined until loaded.
module nearest_palette_color_search (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  npcs_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output npcs_pkg::result_t result
);
    import npcs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_HOLD  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  addr_reg;
    logic [PAL_W-1:0]   pal_cnt_reg;
    logic [IDX_W-1:0]   idx_cnt_reg;
    rgba_t              color_reg;
    rgba_t              rdata_reg;
    tag_t               tag1_reg;
    tag_t               tag_issue;
    tag_t               tag2;
    logic [DIST_W-1:0]  gap_sum;
    logic               first_reg;
    logic [DIST_W-1:0]  best_dist_reg;
    logic [PAL_W-1:0]   best_pal_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic               result_valid_reg;
    result_t            result_reg;

    rgba_t              mem [TOTAL_ENTRIES];

    logic               accept;
    logic               issue;
    logic               last_addr;
    logic               out_free;
    logic               take;
    logic               write_en;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign issue      = (state_reg == S_SCAN);
    assign last_addr  = (addr_reg == ADDR_W'(TOTAL_ENTRIES - 1));
    assign out_free   = !result_valid_reg || result_ready;
    assign write_en   = accept && (item.opcode == OP_LOAD)
                     && (32'(item.entry_number) < TOTAL_ENTRIES);
    assign take       = tag2.valid && (first_reg || (gap_sum < best_dist_reg));

    always_comb
    begin
        tag_issue.valid = issue;
        tag_issue.last  = last_addr;
        tag_issue.pal   = pal_cnt_reg;
        tag_issue.idx   = idx_cnt_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.opcode == OP_QUERY))
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (last_addr)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (tag2.valid && tag2.last)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Store: one write port for loads, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            mem[ADDR_W'(item.entry_number)] <= rgba_t'{item.red, item.green,
                                                       item.blue, item.alpha};
        end
        rdata_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            addr_reg         <= '0;
            pal_cnt_reg      <= '0;
            idx_cnt_reg      <= '0;
            tag1_reg         <= '0;
            first_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tag1_reg  <= tag_issue;

            if (accept && (item.opcode == OP_QUERY))
            begin
                addr_reg    <= '0;
                pal_cnt_reg <= '0;
                idx_cnt_reg <= '0;
                first_reg   <= 1'b1;
            end
            else
            begin
                if (issue)
                begin
                    addr_reg <= addr_reg + ADDR_W'(1);
                    if (idx_cnt_reg == IDX_W'(ENTRIES_PER_PALETTE - 1))
                    begin
                        idx_cnt_reg <= '0;
                        pal_cnt_reg <= pal_cnt_reg + PAL_W'(1);
                    end
                    else
                    begin
                        idx_cnt_reg <= idx_cnt_reg + IDX_W'(1);
                    end
                end
                if (tag2.valid)
                begin
                    first_reg <= 1'b0;
                end
            end

            if ((state_reg == S_HOLD) && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Query color latch, running minimum and result register; strict compare keeps the lowest index on ties.
    always_ff @(posedge clk)
    begin
        if (accept && (item.opcode == OP_QUERY))
        begin
            color_reg <= rgba_t'{item.red, item.green, item.blue, item.alpha};
        end
        if (take)
        begin
            best_dist_reg <= gap_sum;
            best_pal_reg  <= tag2.pal;
            best_idx_reg  <= tag2.idx;
        end
        if ((state_reg == S_HOLD) && out_free)
        begin
            result_reg.palette_number   <= 3'(best_pal_reg);
            result_reg.entry_in_palette <= 4'(best_idx_reg);
            result_reg.best_distance    <= best_dist_reg;
        end
    end

    npcs_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .color   (color_reg),
        .entry   (rdata_reg),
        .tag_in  (tag1_reg),
        .tag_out (tag2),
        .gap_sum (gap_sum)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_query_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.opcode == OP_QUERY)) |=> (state_reg == S_SCAN) && (addr_reg == '0))
        else $error("query did not start scan at entry zero");

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!tag1_reg.valid && !tag2.valid))
        else $error("distance pipeline busy while idle");

    a_last_to_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (tag2.valid && tag2.last) |=> (state_reg == S_HOLD))
        else $error("scan end did not reach result hold");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.best_distance <= DIST_W'(MAX_DIST)))
        else $error("result distance out of range");

endmodule

// File: hdl/npcs_dist.sv
// Squared RGBA distance stage: registered per-component squares, summed on output.
module npcs_dist (
    input  logic                         clk,
    input  logic                         rst_n,
    input  npcs_pkg::rgba_t              color,
    input  npcs_pkg::rgba_t              entry,
    input  npcs_pkg::tag_t               tag_in,
    output npcs_pkg::tag_t               tag_out,
    output logic [npcs_pkg::DIST_W-1:0]  gap_sum
);
    import npcs_pkg::*;

    logic [15:0] sq_reg [4];
    tag_t        tag_reg;

    function automatic logic [15:0] square_gap(input logic [7:0] x, input logic [7:0] y);
        logic [15:0] d;
        begin
            d = (x > y) ? {8'd0, x - y} : {8'd0, y - x};
            return d * d;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg[0] <= square_gap(color.red,   entry.red);
        sq_reg[1] <= square_gap(color.green, entry.green);
        sq_reg[2] <= square_gap(color.blue,  entry.blue);
        sq_reg[3] <= square_gap(color.alpha, entry.alpha);
    end

    assign tag_out = tag_reg;
    assign gap_sum = DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1])
                   + DIST_W'(sq_reg[2]) + DIST_W'(sq_reg[3]);

endmodule

// File: bench/tb_nearest_palette_color_search.sv
// Self-checking bench for the nearest palette color search: loads, queries, stalls.
`timescale 1ns / 1ps

module tb_nearest_palette_color_search;
    import npcs_pkg::*;

    // Mirrors the palette store and queues the nearest-entry answer for each query beat.
    class nearest_color_tracker;
        rgba_t   palette_copy[TOTAL_ENTRIES];
        result_t pending_matches[$];
        int      errors;

        function new();
            errors = 0;
            foreach (palette_copy[k])
            begin
                palette_copy[k] = '0;
            end
        endfunction

        function int unsigned gap_sq(logic [7:0] x, logic [7:0] y);
            int dx;
            dx = int'(x) - int'(y);
            return dx * dx;
        endfunction

        function result_t find_nearest(rgba_t c);
            int unsigned best;
            int unsigned best_at;
            int unsigned d;
            result_t     r;
            best    = 32'hFFFF_FFFF;
            best_at = 0;
            // scan in rising flat order; strict compare keeps the lowest index on a tie
            for (int k = 0; k < TOTAL_ENTRIES; k++)
            begin
                d = gap_sq(c.red,   palette_copy[k].red)
                  + gap_sq(c.green, palette_copy[k].green)
                  + gap_sq(c.blue,  palette_copy[k].blue)
                  + gap_sq(c.alpha, palette_copy[k].alpha);
                if (d < best)
                begin
                    best    = d;
                    best_at = k;
                end
            end
            r.palette_number   = 3'(best_at / ENTRIES_PER_PALETTE);
            r.entry_in_palette = 4'(best_at % ENTRIES_PER_PALETTE);
            r.best_distance    = DIST_W'(best);
            return r;
        endfunction

        function void note_beat(item_t it);
            if (it.opcode == OP_LOAD)
            begin
                if (int'(it.entry_number) < TOTAL_ENTRIES)
                begin
                    palette_copy[it.entry_number] = {it.red, it.green, it.blue, it.alpha};
                end
            end
            else
            begin
                pending_matches.push_back(find_nearest({it.red, it.green, it.blue, it.alpha}));
            end
        endfunction

        function void check_match(result_t got);
            result_t want;
            if (pending_matches.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("%0t: unexpected result beat: pal %0d entry %0d dist %0d", $time,
                             got.palette_number, got.entry_in_palette, got.best_distance);
                end
                return;
            end
            want = pending_matches.pop_front();
            if (got.palette_number !== want.palette_number ||
                got.entry_in_palette !== want.entry_in_palette ||
                got.best_distance !== want.best_distance)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("%0t: mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             $time, want.palette_number, want.entry_in_palette,
                             want.best_distance, got.palette_number,
                             got.entry_in_palette, got.best_distance);
                end
            end
        endfunction

        function int pending();
            return pending_matches.size();
        endfunction
    endclass

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    bit      steady       = 1'b0;
    int      hold_request = 0;

    nearest_color_tracker tracker;

    nearest_palette_color_search i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb_nearest_palette_color_search: done, errors");
        $finish;
    end

    function automatic item_t load_beat(int unsigned slot, logic [31:0] color);
        item_t it;
        it.opcode       = OP_LOAD;
        it.entry_number = 7'(slot);
        {it.red, it.green, it.blue, it.alpha} = color;
        return it;
    endfunction

    // entry_number is don't-care for a query; randomize it anyway
    function automatic item_t query_beat(logic [31:0] color);
        item_t it;
        it.opcode       = OP_QUERY;
        it.entry_number = 7'($urandom);
        {it.red, it.green, it.blue, it.alpha} = color;
        return it;
    endfunction

    // bias toward the levels 00, FF and 80 so duplicate entries and ties show up
    function automatic logic [7:0] pick_level();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] nudge(logic [7:0] v);
        int t;
        t = int'(v) + int'($urandom_range(6)) - 3;
        if (t < 0)
        begin
            t = 0;
        end
        if (t > 255)
        begin
            t = 255;
        end
        return 8'(t);
    endfunction

    task automatic drive_item(input item_t it);
        while (!steady && $urandom_range(99) < 31)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        tracker.note_beat(it);
    endtask

    task automatic pause_until_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Result side: check accepted beats, randomize ready, honor long hold-off requests.
    initial
    begin
        int hold_left;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                tracker.check_match(result);
            end
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= steady || ($urandom_range(99) >= 31);
            end
        end
    end

    initial
    begin
        rgba_t       c;
        int unsigned drain_wait;
        tracker = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // clear every entry so no query ever reads an unloaded slot
        for (int s = 0; s < TOTAL_ENTRIES; s++)
        begin
            drive_item(load_beat(s, 32'h0000_0000));
        end
        drive_item(query_beat(32'hFFFF_FFFF));          // farthest distance, all tied
        drive_item(query_beat(32'h0000_0000));          // exact match, all tied
        drive_item(query_beat(32'h0100_0000));
        drive_item(load_beat(TOTAL_ENTRIES - 1, 32'hFFFF_FFFF));
        drive_item(query_beat(32'hFFFF_FFFF));          // last flat entry wins
        drive_item(load_beat(77, 32'hFF00_FF00));
        drive_item(query_beat(32'hFE01_FE01));
        drive_item(query_beat(32'h00FF_00FF));          // large differences must not wrap
        drive_item(load_beat(16, 32'h8080_8080));
        drive_item(load_beat(17, 32'h8080_8080));
        drive_item(query_beat(32'h8080_8080));          // duplicate entries, lower index wins
        drive_item(query_beat(32'h7F7F_8180));
        pause_until_drained();

        for (int s = 0; s < TOTAL_ENTRIES; s++)
        begin
            drive_item(load_beat(s, {pick_level(), pick_level(), pick_level(), pick_level()}));
        end

        for (int n = 0; n < 1140; n++)
        begin
            steady = (n >= 400 && n < 650);
            if (n == 900)
            begin
                hold_request = 700;
            end
            if (n == 300 || n == 1100)
            begin
                pause_until_drained();
            end
            if ($urandom_range(99) < 40)
            begin
                drive_item(load_beat($urandom_range(TOTAL_ENTRIES - 1),
                                     {pick_level(), pick_level(), pick_level(), pick_level()}));
            end
            else if ($urandom_range(1) == 1)
            begin
                // land near a stored color to get small distances and close calls
                c = tracker.palette_copy[$urandom_range(TOTAL_ENTRIES - 1)];
                drive_item(query_beat({nudge(c.red), nudge(c.green), nudge(c.blue),
                                       nudge(c.alpha)}));
            end
            else
            begin
                drive_item(query_beat($urandom));
            end
        end
        item_valid <= 1'b0;

        drain_wait = 0;
        while (tracker.pending() != 0 && drain_wait < 20000)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (200) @(posedge clk);
        if (tracker.pending() != 0)
        begin
            tracker.errors++;
            $display("%0d expected results never arrived", tracker.pending());
        end

        if (tracker.errors == 0)
        begin
            $display("tb_nearest_palette_color_search: done, clean");
        end
        else
        begin
            $display("tb_nearest_palette_color_search: done, errors");
        end
        $finish;
    end

endmodule
